>>> hw/rtl/rmpa_pkg.sv
// Package for the refcounted message pool allocator core.
// Holds default sizes, request, pool and status codes. No dependencies.
package rmpa_pkg;
	localparam int DEF_COMMON_DEPTH  = 16;
	localparam int DEF_PURE_DEPTH    = 16;
	localparam int DEF_DYNAMIC_DEPTH = 8;
	localparam int DEF_BLOCK_COUNT   = 64;
	localparam int DEF_BLOCK_BYTES   = 16;
	localparam int DEF_REF_MAX       = 15;

	localparam logic [1:0] REQ_ALLOC   = 2'd0;
	localparam logic [1:0] REQ_ADDREF  = 2'd1;
	localparam logic [1:0] REQ_RELEASE = 2'd2;
	localparam logic [1:0] REQ_ATTACH  = 2'd3;

	localparam logic [1:0] POOL_COMMON = 2'd0;
	localparam logic [1:0] POOL_PURE   = 2'd1;
	localparam logic [1:0] POOL_DYN    = 2'd2;

	localparam logic [2:0] ST_OK          = 3'd0;
	localparam logic [2:0] ST_EMPTY       = 3'd1;
	localparam logic [2:0] ST_REF_LIMIT   = 3'd2;
	localparam logic [2:0] ST_NOT_ALLOC   = 3'd3;
	localparam logic [2:0] ST_NOT_DYN     = 3'd4;
	localparam logic [2:0] ST_NO_BLOCKS   = 3'd5;
	localparam logic [2:0] ST_BAD_INDEX   = 3'd6;
	localparam logic [2:0] ST_ATTACHED    = 3'd7;
endpackage

>>> hw/rtl/refcounted_message_pool_allocator_core.sv
// Refcounted message pool allocator core: three descriptor pools and a block pool.
// A request is captured in the idle state and executed in the exec state; attach and a
// dynamic release that returns a chain then go on through the walk state along the chain.
// One request at a time; busy is high while it runs, and a new request can be taken at
// the edge that accepts the result. Reset restores the full free state; block links
// read as the next index until written. Uses rmpa_pkg; the receiver cannot stall.
module refcounted_message_pool_allocator_core
	import rmpa_pkg::*;
#(
	parameter int COMMON_DEPTH  = DEF_COMMON_DEPTH,
	parameter int PURE_DEPTH    = DEF_PURE_DEPTH,
	parameter int DYNAMIC_DEPTH = DEF_DYNAMIC_DEPTH,
	parameter int BLOCK_COUNT   = DEF_BLOCK_COUNT,
	parameter int BLOCK_BYTES   = DEF_BLOCK_BYTES,
	parameter int REF_MAX       = DEF_REF_MAX
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [1:0] req_type,
	input  logic [1:0] pool_sel,
	input  logic [3:0] msg_slot,
	input  logic [10:0] data_length,
	output logic       done,
	output logic [2:0] status,
	output logic [3:0] slot_out,
	output logic [3:0] refs_now,
	output logic [6:0] chain_first,
	output logic [6:0] chain_blocks,
	output logic [4:0] common_free,
	output logic [4:0] pure_free,
	output logic [3:0] dynamic_free,
	output logic [6:0] blocks_free
);
	localparam int CW = $clog2(COMMON_DEPTH + 1);
	localparam int PW = $clog2(PURE_DEPTH + 1);
	localparam int DW = $clog2(DYNAMIC_DEPTH + 1);
	localparam int BW = $clog2(BLOCK_COUNT + 1);
	localparam int RW = $clog2(REF_MAX + 1);
	localparam int NW = $clog2(2048 / BLOCK_BYTES + 2);
	localparam int CI = (COMMON_DEPTH > 1) ? $clog2(COMMON_DEPTH) : 1;
	localparam int PI = (PURE_DEPTH > 1) ? $clog2(PURE_DEPTH) : 1;
	localparam int DI = (DYNAMIC_DEPTH > 1) ? $clog2(DYNAMIC_DEPTH) : 1;
	localparam int BI = $clog2(BLOCK_COUNT);
	localparam logic [BW-1:0] NONE = BW'(BLOCK_COUNT);
	// Reciprocal of the block size, exact for every 12-bit rounded-up length.
	localparam int DSH = 12 + $clog2(BLOCK_BYTES);
	localparam int DMUL = (2 ** DSH + BLOCK_BYTES - 1) / BLOCK_BYTES;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_WALK = 2'd2;

	logic [1:0] state_q;
	logic [1:0] req_q, sel_q;
	logic [3:0] slot_q;
	logic [NW-1:0] need_q, cnt_q;
	logic [BW-1:0] cur_q;

	logic [CW-1:0] c_links_q [COMMON_DEPTH];
	logic [RW-1:0] c_refs_q  [COMMON_DEPTH];
	logic [CW-1:0] c_top_q, c_avail_q;
	logic [PW-1:0] p_links_q [PURE_DEPTH];
	logic [RW-1:0] p_refs_q  [PURE_DEPTH];
	logic [PW-1:0] p_top_q, p_avail_q;
	logic [DW-1:0] d_links_q [DYNAMIC_DEPTH];
	logic [RW-1:0] d_refs_q  [DYNAMIC_DEPTH];
	logic [DW-1:0] d_top_q, d_avail_q;
	logic [BW-1:0] d_cs_q [DYNAMIC_DEPTH];
	logic [BW-1:0] d_ce_q [DYNAMIC_DEPTH];
	logic [BW-1:0] b_head_q, b_tail_q, b_avail_q;

	// Block link table with a registered read; a valid bit marks entries written since reset.
	logic [BW-1:0] b_links_ram [BLOCK_COUNT];
	logic [BLOCK_COUNT-1:0] b_vld_q;
	logic [BW-1:0] b_rd_q;
	logic b_rvld_q;
	logic b_we;
	logic [BI-1:0] b_waddr;
	logic [BW-1:0] b_wdata;
	logic [BW-1:0] rd_addr;

	// Release walk: counts blocks from start to end of the returned chain.
	logic ret_q;

	logic [2:0] st_q;
	logic [3:0] so_q, rn_q;
	logic [BW-1:0] cf_q;
	logic [NW-1:0] cb_q;
	logic done_q;

	logic [11:0] len_sum;
	logic [31:0] need_prod;
	logic [NW-1:0] need_c;
	logic [BW-1:0] next_c;
	logic splice_c;
	assign len_sum = {1'b0, data_length} + 12'(BLOCK_BYTES - 1);
	assign need_prod = 32'(len_sum) * 32'(DMUL);
	assign need_c = NW'(need_prod >> DSH);
	assign next_c = (cur_q < NONE) ? (b_rvld_q ? b_rd_q : cur_q + 1'b1) : NONE;

	assign busy = (state_q != S_IDLE);

	logic [RW-1:0] refc;
	logic slot_ok;
	always_comb begin
		refc = '0;
		slot_ok = 1'b0;
		case (sel_q)
			POOL_COMMON: begin
				slot_ok = 32'(slot_q) < COMMON_DEPTH;
				if (slot_ok) refc = c_refs_q[slot_q[CI-1:0]];
			end
			POOL_PURE: begin
				slot_ok = 32'(slot_q) < PURE_DEPTH;
				if (slot_ok) refc = p_refs_q[slot_q[PI-1:0]];
			end
			POOL_DYN: begin
				slot_ok = 32'(slot_q) < DYNAMIC_DEPTH;
				if (slot_ok) refc = d_refs_q[slot_q[DI-1:0]];
			end
			default: ;
		endcase
	end

	// Last reference of a dynamic descriptor that holds a chain.
	assign splice_c = (state_q == S_EXEC) && sel_q == POOL_DYN && req_q == REQ_RELEASE
		&& slot_ok && refc == RW'(1) && d_cs_q[slot_q[DI-1:0]] < NONE
		&& d_ce_q[slot_q[DI-1:0]] < NONE;

	always_comb begin
		b_we = 1'b0;
		b_waddr = '0;
		b_wdata = '0;
		if (splice_c && !(b_avail_q == '0 || b_tail_q >= NONE)) begin
			b_we = 1'b1;
			b_waddr = b_tail_q[BI-1:0];
			b_wdata = d_cs_q[slot_q[DI-1:0]];
		end else if (state_q == S_WALK && !ret_q && cnt_q == need_q && cur_q < NONE) begin
			b_we = 1'b1;
			b_waddr = cur_q[BI-1:0];
			b_wdata = NONE;
		end
	end

	// The read address is the block that cur_q moves to when a walk starts or steps on.
	always_comb begin
		if (state_q == S_EXEC)
			rd_addr = (req_q == REQ_ATTACH) ? b_head_q : d_cs_q[slot_q[DI-1:0]];
		else
			rd_addr = next_c;
	end

	always_ff @(posedge clk) begin
		if (b_we)
			b_links_ram[b_waddr] <= b_wdata;
		b_rd_q <= b_links_ram[rd_addr[BI-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q <= 1'b0;
			ret_q <= 1'b0;
			for (int i = 0; i < COMMON_DEPTH; i++) begin
				c_links_q[i] <= CW'(i + 1);
				c_refs_q[i] <= '0;
			end
			for (int i = 0; i < PURE_DEPTH; i++) begin
				p_links_q[i] <= PW'(i + 1);
				p_refs_q[i] <= '0;
			end
			for (int i = 0; i < DYNAMIC_DEPTH; i++) begin
				d_links_q[i] <= DW'(i + 1);
				d_refs_q[i] <= '0;
				d_cs_q[i] <= NONE;
				d_ce_q[i] <= NONE;
			end
			b_vld_q <= '0;
			b_rvld_q <= 1'b0;
			c_top_q <= '0; p_top_q <= '0; d_top_q <= '0;
			c_avail_q <= CW'(COMMON_DEPTH);
			p_avail_q <= PW'(PURE_DEPTH);
			d_avail_q <= DW'(DYNAMIC_DEPTH);
			b_head_q <= '0;
			b_tail_q <= BW'(BLOCK_COUNT - 1);
			b_avail_q <= NONE;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						req_q <= req_type;
						sel_q <= pool_sel;
						slot_q <= msg_slot;
						need_q <= need_c;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					st_q <= ST_OK;
					so_q <= slot_q;
					rn_q <= '0;
					cf_q <= NONE;
					cb_q <= '0;
					state_q <= S_IDLE;
					done_q <= 1'b1;
					if (sel_q > POOL_DYN) begin
						st_q <= ST_BAD_INDEX;
					end else if (req_q == REQ_ALLOC) begin
						so_q <= '0;
						case (sel_q)
							POOL_COMMON:
								if (c_avail_q == '0 || 32'(c_top_q) >= COMMON_DEPTH)
									st_q <= ST_EMPTY;
								else begin
									so_q <= 4'(c_top_q); rn_q <= 4'd1;
									c_top_q <= c_links_q[c_top_q[CI-1:0]];
									c_avail_q <= c_avail_q - 1'b1;
									c_refs_q[c_top_q[CI-1:0]] <= RW'(1);
								end
							POOL_PURE:
								if (p_avail_q == '0 || 32'(p_top_q) >= PURE_DEPTH)
									st_q <= ST_EMPTY;
								else begin
									so_q <= 4'(p_top_q); rn_q <= 4'd1;
									p_top_q <= p_links_q[p_top_q[PI-1:0]];
									p_avail_q <= p_avail_q - 1'b1;
									p_refs_q[p_top_q[PI-1:0]] <= RW'(1);
								end
							default:
								if (d_avail_q == '0 || 32'(d_top_q) >= DYNAMIC_DEPTH)
									st_q <= ST_EMPTY;
								else begin
									so_q <= 4'(d_top_q); rn_q <= 4'd1;
									d_top_q <= d_links_q[d_top_q[DI-1:0]];
									d_avail_q <= d_avail_q - 1'b1;
									d_refs_q[d_top_q[DI-1:0]] <= RW'(1);
									d_cs_q[d_top_q[DI-1:0]] <= NONE;
									d_ce_q[d_top_q[DI-1:0]] <= NONE;
								end
						endcase
					end else if (req_q == REQ_ATTACH && sel_q != POOL_DYN) begin
						st_q <= ST_NOT_DYN;
					end else if (!slot_ok) begin
						st_q <= ST_BAD_INDEX;
					end else if (refc == '0) begin
						st_q <= ST_NOT_ALLOC;
					end else if (req_q == REQ_ADDREF) begin
						if (32'(refc) >= REF_MAX) begin
							st_q <= ST_REF_LIMIT;
							rn_q <= 4'(refc);
						end else begin
							rn_q <= 4'(refc + 1'b1);
							case (sel_q)
								POOL_COMMON: c_refs_q[slot_q[CI-1:0]] <= refc + 1'b1;
								POOL_PURE:   p_refs_q[slot_q[PI-1:0]] <= refc + 1'b1;
								default:     d_refs_q[slot_q[DI-1:0]] <= refc + 1'b1;
							endcase
						end
					end else if (req_q == REQ_RELEASE) begin
						rn_q <= 4'(refc - 1'b1);
						case (sel_q)
							POOL_COMMON: begin
								c_refs_q[slot_q[CI-1:0]] <= refc - 1'b1;
								if (refc == RW'(1)) begin
									c_links_q[slot_q[CI-1:0]] <= c_top_q;
									c_top_q <= CW'(slot_q);
									c_avail_q <= c_avail_q + 1'b1;
								end
							end
							POOL_PURE: begin
								p_refs_q[slot_q[PI-1:0]] <= refc - 1'b1;
								if (refc == RW'(1)) begin
									p_links_q[slot_q[PI-1:0]] <= p_top_q;
									p_top_q <= PW'(slot_q);
									p_avail_q <= p_avail_q + 1'b1;
								end
							end
							default: begin
								d_refs_q[slot_q[DI-1:0]] <= refc - 1'b1;
								if (refc == RW'(1)) begin
									d_links_q[slot_q[DI-1:0]] <= d_top_q;
									d_top_q <= DW'(slot_q);
									d_avail_q <= d_avail_q + 1'b1;
									d_cs_q[slot_q[DI-1:0]] <= NONE;
									d_ce_q[slot_q[DI-1:0]] <= NONE;
									if (d_cs_q[slot_q[DI-1:0]] < NONE
										&& d_ce_q[slot_q[DI-1:0]] < NONE) begin
										// Splice the chain on now and count it in the walk.
										done_q <= 1'b0;
										ret_q <= 1'b1;
										cur_q <= d_cs_q[slot_q[DI-1:0]];
										cnt_q <= NW'(1);
										state_q <= S_WALK;
									end
								end
							end
						endcase
					end else begin
						rn_q <= 4'(refc);
						if (d_cs_q[slot_q[DI-1:0]] < NONE) begin
							st_q <= ST_ATTACHED;
						end else if (32'(need_q) > 32'(b_avail_q)) begin
							st_q <= ST_NO_BLOCKS;
						end else if (need_q != '0) begin
							done_q <= 1'b0;
							ret_q <= 1'b0;
							cur_q <= b_head_q;
							cnt_q <= NW'(1);
							state_q <= S_WALK;
						end
					end
				end
				S_WALK: begin
					if (ret_q) begin
						if (cur_q != b_tail_q && 32'(cnt_q) < BLOCK_COUNT
							&& next_c < NONE) begin
							cur_q <= next_c;
							cnt_q <= cnt_q + 1'b1;
						end else begin
							// The splice already made the chain end the list tail.
							state_q <= S_IDLE;
							done_q <= 1'b1;
							ret_q <= 1'b0;
						end
					end else if (cnt_q != need_q) begin
						cur_q <= next_c;
						cnt_q <= cnt_q + 1'b1;
					end else begin
						cf_q <= b_head_q;
						cb_q <= need_q;
						b_head_q <= (b_avail_q == BW'(need_q)) ? NONE : next_c;
						b_avail_q <= b_avail_q - BW'(need_q);
						d_cs_q[slot_q[DI-1:0]] <= b_head_q;
						d_ce_q[slot_q[DI-1:0]] <= cur_q;
						state_q <= S_IDLE;
						done_q <= 1'b1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			b_rvld_q <= b_vld_q[rd_addr[BI-1:0]];
			if (b_we)
				b_vld_q[b_waddr] <= 1'b1;
			if (splice_c) begin
				// Splice now; the count follows after the walk.
				if (b_avail_q == '0 || b_tail_q >= NONE)
					b_head_q <= d_cs_q[slot_q[DI-1:0]];
				b_tail_q <= d_ce_q[slot_q[DI-1:0]];
			end
			if (state_q == S_WALK && ret_q && !(cur_q != b_tail_q
				&& 32'(cnt_q) < BLOCK_COUNT && next_c < NONE)) begin
				b_avail_q <= (32'(b_avail_q) + 32'(cnt_q) > BLOCK_COUNT) ? NONE
					: b_avail_q + BW'(cnt_q);
			end
		end
	end

	assign done = done_q;
	assign status = st_q;
	assign slot_out = so_q;
	assign refs_now = rn_q;
	assign chain_first = 7'(cf_q);
	assign chain_blocks = 7'(cb_q);
	assign common_free = 5'(c_avail_q);
	assign pure_free = 5'(p_avail_q);
	assign dynamic_free = 4'(d_avail_q);
	assign blocks_free = 7'(b_avail_q);

	a_no_done_idle_start: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> !done) else $error("result without execution");
	a_blocks_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(b_avail_q) <= BLOCK_COUNT) else $error("block count overflow");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result while busy");
endmodule
